// File: rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, sizes and codes of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int POS_W      = 7;
  localparam int FUNC_W     = 2;
  localparam int STS_W      = 2;

  localparam int GRP_SIZE   = 8;
  localparam int GRP_CNT    = LIST_DEPTH / GRP_SIZE;
  localparam int GRP_W      = $clog2(GRP_SIZE);
  localparam int GSEL_W     = IDX_W - GRP_W;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOCATE = 2'd3;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;
  localparam logic [STS_W-1:0] STS_RANGE = 2'd3;

  typedef logic [DATA_W-1:0] data_t;

  typedef struct packed {
    logic             exec;
    logic             do_ins;
    logic             do_del;
    logic             rd_sel;
    logic             is_loc;
    logic [IDX_W-1:0] pos_idx;
    logic [CNT_W-1:0] count;
    data_t            value;
  } cell_cmd_t;

endpackage

// File: rtl/core/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: shifts with its neighbors, flags a match, offers its word.
// ----------------------------------------------------------------------------
module ple_cell
  import ple_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_cmd_t        cmd,
  input  data_t            left_val,
  input  data_t            right_val,
  output data_t            entry_r,
  output logic             hit_r,
  output data_t            data_r
);

  data_t entry_nxt;
  logic  at_pos;
  logic  past_pos;

  assign at_pos   = (idx == cmd.pos_idx);
  assign past_pos = (idx > cmd.pos_idx);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.exec && cmd.do_ins) begin
      if (at_pos) begin
        entry_nxt = cmd.value;
      end else if (past_pos) begin
        entry_nxt = left_val;
      end
    end else if (cmd.exec && cmd.do_del) begin
      if (at_pos || past_pos) begin
        entry_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (cmd.exec) begin
      hit_r  <= cmd.is_loc && ({1'b0, idx} < cmd.count) && (entry_r == cmd.value);
      data_r <= (cmd.rd_sel && at_pos) ? entry_r : '0;
    end
  end

endmodule

// File: rtl/core/ple_reduce.sv
// ----------------------------------------------------------------------------
// ple_reduce
// Two-level priority and OR tree over the cell flags and read words.
// ----------------------------------------------------------------------------
module ple_reduce
  import ple_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [LIST_DEPTH-1:0] hit,
  input  data_t                 data [LIST_DEPTH],
  output logic                  any_hit,
  output logic [IDX_W-1:0]      hit_idx,
  output data_t                 data_or
);

  logic [GRP_CNT-1:0] grp_any_nxt;
  logic [GRP_CNT-1:0] grp_any_r;
  logic [GRP_W-1:0]   grp_loc_nxt [GRP_CNT];
  logic [GRP_W-1:0]   grp_loc_r   [GRP_CNT];
  data_t              grp_data_nxt [GRP_CNT];
  data_t              grp_data_r   [GRP_CNT];

  always_comb begin
    for (int g = 0; g < GRP_CNT; g++) begin
      grp_any_nxt[g]  = 1'b0;
      grp_loc_nxt[g]  = '0;
      grp_data_nxt[g] = '0;
      for (int j = GRP_SIZE - 1; j >= 0; j--) begin
        if (hit[g*GRP_SIZE + j]) begin
          grp_loc_nxt[g] = GRP_W'(j);
        end
        grp_any_nxt[g]  = grp_any_nxt[g] | hit[g*GRP_SIZE + j];
        grp_data_nxt[g] = grp_data_nxt[g] | data[g*GRP_SIZE + j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_any_r  <= grp_any_nxt;
      grp_loc_r  <= grp_loc_nxt;
      grp_data_r <= grp_data_nxt;
    end
  end

  always_comb begin
    any_hit = |grp_any_r;
    hit_idx = '0;
    data_or = '0;
    for (int g = GRP_CNT - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        hit_idx = {GSEL_W'(g), grp_loc_r[g]};
      end
      data_or = data_or | grp_data_r[g];
    end
  end

endmodule

// File: rtl/core/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of LIST_DEPTH words with insert, delete, get and locate.
// ----------------------------------------------------------------------------
// channel  dir  bits  fields (low bit first)
// in_      in   48    func[1:0] position[8:2] value[40:9]
// out_     out  48    value_out[31:0] found_position[38:32] status[40:39]
//                     count_out[47:41]
// A result passes through the cell row, which shifts and compares, then the
// group registers of the reduce tree, then the output reg.
// A new word is taken only in the idle state; a result that is not taken
// holds the engine in its last stage and keeps in_tready low.
// The output register lets the next item start while a result waits.
// Reset empties the list; the entry words keep no reset value.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // func, position, value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // value_out, found_position, status, count_out
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_CELL = 2'd2;
  localparam logic [1:0] ST_GRP  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [FUNC_W-1:0] func_r;
  logic [POS_W-1:0]  pos_r;
  data_t             value_r;
  logic [STS_W-1:0]  sts_r, sts_nxt;
  logic              loc_r;
  logic              out_tvalid_r;
  logic [47:0]       out_tdata_r;

  cell_cmd_t             cmd;
  data_t                 entry   [LIST_DEPTH];
  data_t                 rd_data [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] hit;
  logic                  any_hit;
  logic [IDX_W-1:0]      hit_idx;
  data_t                 data_or;
  logic                  in_fire;
  logic                  out_load;
  logic                  pos_bad_ins;
  logic                  pos_bad_rd;
  logic [POS_W-1:0]      found;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_GRP) && (!out_tvalid_r || out_tready);

  assign pos_bad_ins = (pos_r == '0) || ({1'b0, pos_r} > ({1'b0, count_r} + 8'd1));
  assign pos_bad_rd  = (pos_r == '0) || (pos_r > count_r);

  always_comb begin
    sts_nxt     = STS_OK;
    count_nxt   = count_r;
    cmd         = '0;
    cmd.exec    = (state_r == ST_EXEC);
    cmd.pos_idx = IDX_W'(pos_r - 7'd1);
    cmd.count   = count_r;
    cmd.value   = value_r;
    case (func_r)
      FUNC_INSERT: begin
        if (count_r == CNT_W'(LIST_DEPTH)) begin
          sts_nxt = STS_FULL;
        end else if (pos_bad_ins) begin
          sts_nxt = STS_RANGE;
        end else begin
          cmd.do_ins = 1'b1;
          count_nxt  = count_r + 7'd1;
        end
      end
      FUNC_DELETE: begin
        if (count_r == '0) begin
          sts_nxt = STS_EMPTY;
        end else if (pos_bad_rd) begin
          sts_nxt = STS_RANGE;
        end else begin
          cmd.do_del = 1'b1;
          cmd.rd_sel = 1'b1;
          count_nxt  = count_r - 7'd1;
        end
      end
      FUNC_GET: begin
        if (pos_bad_rd) begin
          sts_nxt = STS_RANGE;
        end else begin
          cmd.rd_sel = 1'b1;
        end
      end
      default: begin
        cmd.is_loc = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_CELL;
      ST_CELL: state_nxt = ST_GRP;
      ST_GRP:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EXEC) begin
        count_r <= count_nxt;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r  <= in_tdata[1:0];
      pos_r   <= in_tdata[8:2];
      value_r <= in_tdata[40:9];
    end
    if (state_r == ST_EXEC) begin
      sts_r <= sts_nxt;
      loc_r <= cmd.is_loc;
    end
    if (out_load) begin
      out_tdata_r <= {count_r, sts_r, found, data_or};
    end
  end

  assign found = (loc_r && any_hit) ? ({1'b0, hit_idx} + 7'd1) : '0;

  genvar k;
  generate
    for (k = 0; k < LIST_DEPTH; k++) begin : g_cell
      data_t left_v, right_v;
      if (k == 0) begin : g_first
        assign left_v = '0;
      end else begin : g_left
        assign left_v = entry[k-1];
      end
      if (k == LIST_DEPTH - 1) begin : g_last
        assign right_v = '0;
      end else begin : g_right
        assign right_v = entry[k+1];
      end
      ple_cell u_cell (
        .clk       (clk),
        .idx       (IDX_W'(k)),
        .cmd       (cmd),
        .left_val  (left_v),
        .right_val (right_v),
        .entry_r   (entry[k]),
        .hit_r     (hit[k]),
        .data_r    (rd_data[k])
      );
    end
  endgenerate

  ple_reduce u_reduce (
    .clk     (clk),
    .en      (state_r == ST_CELL),
    .hit     (hit),
    .data    (rd_data),
    .any_hit (any_hit),
    .hit_idx (hit_idx),
    .data_or (data_or)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
